// ===== src/sidf_pkg.sv =====
`timescale 1ns / 1ps

package sidf_pkg;

   // table geometry
   localparam int TABLE_DEPTH   = 256;
   localparam int ADDR_W        = $clog2(TABLE_DEPTH);
   localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W         = 32;
   localparam int ENTRY_COUNT_W = 9;

   // item actions
   typedef enum logic [1:0] {
      ACT_QUERY  = 2'd0,
      ACT_ADD    = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef struct packed {
      action_type       action;
      logic [KEY_W-1:0] key;
      logic             start_of_pass;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic                     dropped;
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic                     changed;
   } rsp_type;

   // read address sources
   typedef enum logic [2:0] {
      RD_LAST,
      RD_CURSOR,
      RD_CURSOR_P1,
      RD_IDX,
      RD_IDX_M1,
      RD_IDX_P1
   } rd_sel_type;

   // write data sources
   typedef enum logic {
      WR_SHIFT,
      WR_KEY
   } wr_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_Q_LAST,
      ST_Q_CHK,
      ST_Q_WALK,
      ST_F_RD,
      ST_F_CHK,
      ST_INS_TEST,
      ST_INS_WR,
      ST_DEL_TEST,
      ST_DEL_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       cursor_inc;
      logic       idx_inc;
      logic       idx_dec;
      logic       idx_load_count;
      logic       pos_load;
      logic       count_inc;
      logic       count_dec;
      logic       changed_set;
      logic       set_found;
      logic       set_dropped;
      logic       rsp_fire;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       count_zero;
      logic       full;
      logic       cursor_at_end;
      logic       cursor_next_end;
      logic       idx_at_count;
      logic       idx_next_count;
      logic       idx_eq_pos;
      logic       rd_eq;
      logic       rd_lt;
   } status_type;

endpackage

// ===== src/sidf_datapath.sv =====
`timescale 1ns / 1ps

module sidf_datapath import sidf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_item,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp_item
);

   logic [KEY_W-1:0] mem [TABLE_DEPTH];

   logic [KEY_W-1:0] key_ff;
   action_type       action_ff;
   logic [KEY_W-1:0] rd_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cursor_ff, cursor_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pos_ff;
   logic             changed_ff, changed_in;
   logic             found_ff, found_in;
   logic             dropped_ff, dropped_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic [CNT_W-1:0]  rd_ptr;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [KEY_W-1:0]  wr_data;
   logic [CNT_W-1:0]  count_m1;
   logic [CNT_W-1:0]  cursor_p1;
   logic [CNT_W-1:0]  idx_p1;
   logic [CNT_W-1:0]  idx_m1;
   logic              rewind;

   assign count_m1  = count_ff - 1'b1;
   assign cursor_p1 = cursor_ff + 1'b1;
   assign idx_p1    = idx_ff + 1'b1;
   assign idx_m1    = idx_ff - 1'b1;

   // read address select
   always_comb begin
      case (cmd.rd_sel)
         RD_LAST:      rd_ptr = count_m1;
         RD_CURSOR:    rd_ptr = cursor_ff;
         RD_CURSOR_P1: rd_ptr = cursor_p1;
         RD_IDX:       rd_ptr = idx_ff;
         RD_IDX_M1:    rd_ptr = idx_m1;
         RD_IDX_P1:    rd_ptr = idx_p1;
         default:      rd_ptr = idx_ff;
      endcase
   end

   assign rd_addr = rd_ptr[ADDR_W-1:0];
   assign wr_addr = idx_ff[ADDR_W-1:0];
   assign wr_data = (cmd.wr_sel == WR_KEY) ? key_ff : rd_ff;

   // id table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // a query with start of pass, add and remove all rewind the cursor
   assign rewind = (req_item.action == ACT_QUERY && req_item.start_of_pass) ||
                   (req_item.action inside {ACT_ADD, ACT_REMOVE});

   // next values of the control registers
   always_comb begin
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      idx_in     = idx_ff;
      changed_in = changed_ff;
      found_in   = found_ff;
      dropped_in = dropped_ff;
      if (cmd.load) begin
         idx_in     = '0;
         found_in   = 1'b0;
         dropped_in = 1'b0;
         if (rewind) begin
            cursor_in = '0;
         end
         if (req_item.action == ACT_CLEAR) begin
            changed_in = 1'b0;
         end
      end
      if (cmd.cursor_inc)     cursor_in  = cursor_p1;
      if (cmd.idx_inc)        idx_in     = idx_p1;
      if (cmd.idx_dec)        idx_in     = idx_m1;
      if (cmd.idx_load_count) idx_in     = count_ff;
      if (cmd.count_inc)      count_in   = count_ff + 1'b1;
      if (cmd.count_dec)      count_in   = count_m1;
      if (cmd.changed_set)    changed_in = 1'b1;
      if (cmd.set_found)      found_in   = 1'b1;
      if (cmd.set_dropped)    dropped_in = 1'b1;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         changed_ff   <= 1'b0;
         found_ff     <= 1'b0;
         dropped_ff   <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         changed_ff   <= changed_in;
         found_ff     <= found_in;
         dropped_ff   <= dropped_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= cmd.rsp_fire;
      end
   end

   // item payload and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff    <= req_item.key;
         action_ff <= req_item.action;
      end
      if (cmd.pos_load) begin
         pos_ff <= idx_ff;
      end
      if (cmd.rsp_fire) begin
         rsp_ff.found       <= found_ff;
         rsp_ff.dropped     <= dropped_ff;
         rsp_ff.entry_count <= ENTRY_COUNT_W'(count_ff);
         rsp_ff.changed     <= changed_ff;
      end
   end

   // status towards the controller
   always_comb begin
      status.action          = action_ff;
      status.count_zero      = (count_ff == '0);
      status.full            = (count_ff == CNT_W'(TABLE_DEPTH));
      status.cursor_at_end   = (cursor_ff == count_ff);
      status.cursor_next_end = (cursor_p1 == count_ff);
      status.idx_at_count    = (idx_ff == count_ff);
      status.idx_next_count  = (idx_p1 == count_ff);
      status.idx_eq_pos      = (idx_ff == pos_ff);
      status.rd_eq           = (rd_ff == key_ff);
      status.rd_lt           = (rd_ff < key_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== src/sidf_controller.sv =====
`timescale 1ns / 1ps

module sidf_controller import sidf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  action_type req_action,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_QUERY:  state_in = ST_Q_LAST;
                  ACT_ADD:    state_in = ST_F_RD;
                  ACT_REMOVE: state_in = ST_F_RD;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_Q_LAST: begin
            state_in = status.count_zero ? ST_DONE : ST_Q_CHK;
         end
         ST_Q_CHK: begin
            // key above largest entry, or cursor already at the end
            if (status.rd_lt || status.cursor_at_end) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_Q_WALK;
            end
         end
         ST_Q_WALK: begin
            if (!status.rd_lt || status.cursor_next_end) begin
               state_in = ST_DONE;
            end
         end
         ST_F_RD: begin
            if (status.idx_at_count) begin
               if (status.action == ACT_ADD && !status.full) begin
                  state_in = ST_INS_TEST;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               state_in = ST_F_CHK;
            end
         end
         ST_F_CHK: begin
            if (status.rd_lt) begin
               state_in = ST_F_RD;
            end else if (status.rd_eq) begin
               state_in = (status.action == ACT_REMOVE) ? ST_DEL_TEST : ST_DONE;
            end else if (status.action == ACT_ADD && !status.full) begin
               state_in = ST_INS_TEST;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_INS_TEST: begin
            state_in = status.idx_eq_pos ? ST_DONE : ST_INS_WR;
         end
         ST_INS_WR: begin
            state_in = ST_INS_TEST;
         end
         ST_DEL_TEST: begin
            state_in = status.idx_next_count ? ST_DONE : ST_DEL_WR;
         end
         ST_DEL_WR: begin
            state_in = ST_DEL_TEST;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RD_IDX;
      cmd.wr_sel = WR_SHIFT;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = accept;
         end
         ST_Q_LAST: begin
            cmd.rd_en  = !status.count_zero;
            cmd.rd_sel = RD_LAST;
         end
         ST_Q_CHK: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_CURSOR;
         end
         ST_Q_WALK: begin
            if (status.rd_eq) begin
               cmd.set_found = 1'b1;
            end else if (status.rd_lt) begin
               cmd.cursor_inc = 1'b1;
               cmd.rd_en      = 1'b1;
               cmd.rd_sel     = RD_CURSOR_P1;
            end
         end
         ST_F_RD: begin
            if (status.idx_at_count) begin
               // key is absent and belongs at the end
               if (status.action == ACT_ADD) begin
                  cmd.set_dropped    = status.full;
                  cmd.pos_load       = !status.full;
                  cmd.idx_load_count = !status.full;
               end
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX;
            end
         end
         ST_F_CHK: begin
            if (status.rd_lt) begin
               cmd.idx_inc = 1'b1;
            end else if (!status.rd_eq && status.action == ACT_ADD) begin
               cmd.set_dropped    = status.full;
               cmd.pos_load       = !status.full;
               cmd.idx_load_count = !status.full;
            end
         end
         ST_INS_TEST: begin
            if (status.idx_eq_pos) begin
               cmd.wr_en       = 1'b1;
               cmd.wr_sel      = WR_KEY;
               cmd.count_inc   = 1'b1;
               cmd.changed_set = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_M1;
            end
         end
         ST_INS_WR: begin
            // move one entry up
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_SHIFT;
            cmd.idx_dec = 1'b1;
         end
         ST_DEL_TEST: begin
            if (status.idx_next_count) begin
               cmd.count_dec   = 1'b1;
               cmd.changed_set = 1'b1;
               cmd.set_found   = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_P1;
            end
         end
         ST_DEL_WR: begin
            // move one entry down
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_SHIFT;
            cmd.idx_inc = 1'b1;
         end
         ST_DONE: begin
            cmd.rsp_fire = 1'b1;
         end
         default: begin
            cmd.rsp_fire = 1'b0;
         end
      endcase
   end

endmodule

// ===== src/sorted_id_set_filter.sv =====
// from acceptance to the result strobe: a clear goes straight to the result; a query reads
//   the last entry unless the table is empty, then walks the cursor past entries below the
//   key; add/remove compare entries from the start, then move entries for an insert/delete
// throughput: items are handled one at a time, paced by the single registered read port of the
//   id table; the next item is taken once busy falls; the receiver cannot stall
// reset (synchronous) empties the table, rewinds the cursor and clears the changed flag
`timescale 1ns / 1ps

module sorted_id_set_filter import sidf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   sidf_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_item.action),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd)
   );

   // table, cursor, counters and result register
   sidf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
